@@ rtl/core/lrrs_pkg.sv @@
// Package for the link retry and refresh scheduler.
// Holds field widths, beat layouts, register indexes and reset values.
// No dependencies.
`default_nettype none

package lrrs_pkg;

	localparam int TIME_W     = 32;
	localparam int LIMIT_W    = 4;
	localparam int SPAN_W     = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Slave beat: now_ms, link_up, attempt_link_up, random_offset, zero fill
	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 1;
	// Master beat: five status flags, zero fill
	localparam int OUT_DATA_W = 8;

	localparam int IN_NOW_LSB  = 0;
	localparam int IN_LINK_BIT = 32;
	localparam int IN_ATT_BIT  = 33;
	localparam int IN_RND_LSB  = 34;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RETRY_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RETRY_LIMIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_INTERVAL_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_INTERVAL_SPAN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_INTERVAL       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_MIN_GAP        = 3'd5;

	localparam logic [TIME_W-1:0]  RST_INITIAL_RETRY_INTERVAL = 32'd60000;
	localparam logic [LIMIT_W-1:0] RST_INITIAL_RETRY_LIMIT    = 4'd10;
	localparam logic [TIME_W-1:0]  RST_IDLE_INTERVAL_MIN      = 32'd2400000;
	localparam logic [SPAN_W-1:0]  RST_IDLE_INTERVAL_SPAN     = 31'd1200000;
	localparam logic [TIME_W-1:0]  RST_REFRESH_INTERVAL       = 32'd3600000;
	localparam logic [TIME_W-1:0]  RST_REFRESH_MIN_GAP        = 32'd60000;

	localparam logic [LIMIT_W-1:0] RETRY_COUNT_MAX = '1;

endpackage

`default_nettype wire

@@ rtl/core/link_retry_and_refresh_scheduler.sv @@
// Top level of the link retry and refresh scheduler.
// Uses lrrs_pkg for widths, beat layout, register indexes and reset values.
// Holds the input register, the decision logic, the scheduler state and the result register.
`default_nettype none

// One poll beat in gives one result beat out. A beat is captured in an input
// register, evaluated against the scheduler state by a single pass of
// subtract/compare logic, and the result lands in an output register
// while the state updates on the same edge, so a new beat is taken every
// cycle when the master side is not stalling: one beat per cycle sustained,
// with stalls on the master side holding the pipe.
// tuser on the slave side carries the action (0 poll, 1 restart into the
// initial phase). All time differences wrap modulo 2^32. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must do so only while no
// beat is in flight, which the block does not enforce; indexes 6 and 7 are ignored.
module link_retry_and_refresh_scheduler (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration write port
	input  wire                                  cfg_we,
	input  wire [lrrs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [lrrs_pkg::CFG_DATA_W-1:0]       cfg_data,
	// poll stream
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// [31:0] now_ms, [32] link_up, [33] attempt_link_up,
	// [65:34] random_offset, [71:66] zero
	input  wire [lrrs_pkg::IN_DATA_W-1:0]        s_tdata,
	// [0] action
	input  wire [lrrs_pkg::IN_USER_W-1:0]        s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// [0] attempt_issued, [1] is_online, [2] in_idle_phase,
	// [3] refresh_issued, [4] refresh_throttled, [7:5] zero
	output logic [lrrs_pkg::OUT_DATA_W-1:0]      m_tdata
);
	import lrrs_pkg::*;

	// configuration registers
	logic [TIME_W-1:0]  init_ivl_q;
	logic [LIMIT_W-1:0] init_limit_q;
	logic [TIME_W-1:0]  idle_min_q;
	logic [SPAN_W-1:0]  idle_span_q;
	logic [TIME_W-1:0]  refresh_ivl_q;
	logic [TIME_W-1:0]  refresh_gap_q;

	// scheduler state
	logic               online_q;
	logic               idle_phase_q;
	logic [LIMIT_W-1:0] failed_q;
	logic [TIME_W-1:0]  last_retry_q;
	logic [TIME_W-1:0]  idle_ivl_q;
	logic [TIME_W-1:0]  last_refresh_q;
	logic [TIME_W-1:0]  last_try_q;
	logic               try_valid_q;

	// input register
	logic               valid_s1;
	logic               restart_s1;
	logic [TIME_W-1:0]  now_s1;
	logic               link_s1;
	logic               att_link_s1;
	logic [TIME_W-1:0]  rnd_s1;

	logic advance;

	// The input stage moves on when the output register is empty or drains now.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ivl_q    <= RST_INITIAL_RETRY_INTERVAL;
			init_limit_q  <= RST_INITIAL_RETRY_LIMIT;
			idle_min_q    <= RST_IDLE_INTERVAL_MIN;
			idle_span_q   <= RST_IDLE_INTERVAL_SPAN;
			refresh_ivl_q <= RST_REFRESH_INTERVAL;
			refresh_gap_q <= RST_REFRESH_MIN_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INITIAL_RETRY_INTERVAL: init_ivl_q    <= cfg_data[TIME_W-1:0];
				REG_INITIAL_RETRY_LIMIT:    init_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_IDLE_INTERVAL_MIN:      idle_min_q    <= cfg_data[TIME_W-1:0];
				REG_IDLE_INTERVAL_SPAN:     idle_span_q   <= cfg_data[SPAN_W-1:0];
				REG_REFRESH_INTERVAL:       refresh_ivl_q <= cfg_data[TIME_W-1:0];
				REG_REFRESH_MIN_GAP:        refresh_gap_q <= cfg_data[TIME_W-1:0];
				default: ; // drop writes outside the register list
			endcase
		end
	end

	// Capture the poll beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			restart_s1  <= s_tuser[0];
			now_s1      <= s_tdata[IN_NOW_LSB +: TIME_W];
			link_s1     <= s_tdata[IN_LINK_BIT];
			att_link_s1 <= s_tdata[IN_ATT_BIT];
			rnd_s1      <= s_tdata[IN_RND_LSB +: TIME_W];
		end
	end

	// Decision logic
	logic               online_d;
	logic               idle_phase_d;
	logic [LIMIT_W-1:0] failed_d;
	logic [LIMIT_W-1:0] failed_inc;
	logic [TIME_W-1:0]  last_retry_d;
	logic [TIME_W-1:0]  idle_ivl_d;
	logic [TIME_W-1:0]  last_refresh_d;
	logic [TIME_W-1:0]  last_try_d;
	logic               try_valid_d;
	logic               attempt;
	logic               refresh;
	logic               throttled;

	logic [TIME_W-1:0]  retry_ivl;
	logic [TIME_W-1:0]  since_retry;
	logic [TIME_W-1:0]  span_top;
	logic [TIME_W-1:0]  rnd_off;
	logic [TIME_W:0]    idle_sum;
	logic [TIME_W-1:0]  idle_draw;
	logic [TIME_W-1:0]  ref_base;
	logic               ref_valid;
	logic [TIME_W-1:0]  since_refresh;
	logic [TIME_W-1:0]  since_try;

	always_comb begin
		// fresh idle interval: min + min(rnd, span-1), or min alone when span is 0, saturated
		span_top = {1'b0, idle_span_q} - TIME_W'(1);
		if (idle_span_q == '0) begin
			rnd_off = '0;
		end else begin
			rnd_off = (rnd_s1 < span_top) ? rnd_s1 : span_top;
		end
		idle_sum  = {1'b0, idle_min_q} + {1'b0, rnd_off};
		idle_draw = idle_sum[TIME_W] ? '1 : idle_sum[TIME_W-1:0];

		retry_ivl   = idle_phase_q ? idle_ivl_q : init_ivl_q;
		since_retry = now_s1 - last_retry_q;
		failed_inc  = (failed_q == RETRY_COUNT_MAX) ? failed_q : failed_q + LIMIT_W'(1);

		// refresh bookkeeping restarts when the link has just come up
		ref_base      = online_q ? last_refresh_q : '0;
		ref_valid     = online_q && try_valid_q;
		since_refresh = now_s1 - ref_base;
		since_try     = now_s1 - last_try_q;

		online_d       = online_q;
		idle_phase_d   = idle_phase_q;
		failed_d       = failed_q;
		last_retry_d   = last_retry_q;
		idle_ivl_d     = idle_ivl_q;
		last_refresh_d = last_refresh_q;
		last_try_d     = last_try_q;
		try_valid_d    = try_valid_q;
		attempt        = 1'b0;
		refresh        = 1'b0;
		throttled      = 1'b0;

		if (restart_s1) begin
			idle_phase_d = 1'b0;
			failed_d     = '0;
			last_retry_d = '0;
		end else begin
			online_d = link_s1;
			if (!link_s1 && since_retry >= retry_ivl) begin
				attempt      = 1'b1;
				last_retry_d = now_s1;
				online_d     = att_link_s1;
				if (!att_link_s1) begin
					if (!idle_phase_q) begin
						failed_d = failed_inc;
						if (failed_inc >= init_limit_q) begin
							idle_phase_d = 1'b1;
							idle_ivl_d   = idle_draw;
						end
					end else begin
						idle_ivl_d = idle_draw;
					end
				end
			end
			if (online_d) begin
				last_refresh_d = ref_base;
				try_valid_d    = ref_valid;
				if (since_refresh >= refresh_ivl_q) begin
					if (ref_valid && since_try < refresh_gap_q) begin
						throttled = 1'b1;
					end else begin
						refresh        = 1'b1;
						last_try_d     = now_s1;
						try_valid_d    = 1'b1;
						last_refresh_d = now_s1;
					end
				end
			end
		end
	end

	// Commit state as the beat leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q       <= 1'b0;
			idle_phase_q   <= 1'b0;
			failed_q       <= '0;
			last_retry_q   <= '0;
			idle_ivl_q     <= RST_IDLE_INTERVAL_MIN;
			last_refresh_q <= '0;
			last_try_q     <= '0;
			try_valid_q    <= 1'b0;
		end else if (advance) begin
			online_q       <= online_d;
			idle_phase_q   <= idle_phase_d;
			failed_q       <= failed_d;
			last_retry_q   <= last_retry_d;
			idle_ivl_q     <= idle_ivl_d;
			last_refresh_q <= last_refresh_d;
			last_try_q     <= last_try_d;
			try_valid_q    <= try_valid_d;
		end
	end

	// Result register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {{(OUT_DATA_W-5){1'b0}}, throttled, refresh, idle_phase_d,
				online_d, attempt};
		end
	end

endmodule

`default_nettype wire
